FILE: rtl/core/dpf_pkg.sv
// Package for the debug packet framer: word types, character codes,
// queue sizing and the hex digit helper. No dependencies.
package dpf_pkg;

    // Framing characters
    localparam logic [7:0] CH_START  = 8'h24;   // '$'
    localparam logic [7:0] CH_HASH   = 8'h23;   // '#'
    localparam logic [7:0] CH_ESCAPE = 8'h7D;   // '}'
    localparam logic [7:0] ESC_XOR   = 8'h20;

    // Command queue sizing (depth must be a power of two)
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_packet;
    } item_t;

    // Result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       end_of_packet;
    } result_t;

    // Classified command passed from front to back
    typedef struct packed {
        logic       need_start;   // emit '$' first
        logic       has_data;     // a payload character follows
        logic       escaped;      // payload goes out as '}' + char
        logic [7:0] data_char;    // character after any escape
        logic       close;        // emit '#' and checksum digits
        logic [7:0] sum;          // checksum at close
    } cmd_t;

    // Queue status toward the front, the back and the checks
    typedef struct packed {
        logic               full;
        logic               head_valid;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

    // Output step, one-hot
    typedef enum logic [5:0] {
        STEP_START = 6'b000001,
        STEP_ESC   = 6'b000010,
        STEP_DATA  = 6'b000100,
        STEP_HASH  = 6'b001000,
        STEP_HI    = 6'b010000,
        STEP_LO    = 6'b100000
    } step_t;

    // Lower-case hex character of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] w;
        w = {4'h0, v};
        return (v < 4'd10) ? (8'h30 + w) : (8'h61 + w - 8'd10);
    endfunction

endpackage

FILE: rtl/core/dpf_front.sv
// Front end of the framer: accepts input words, tracks packet state and
// the running checksum, and builds one command per word. Uses dpf_pkg.
module dpf_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             full,
    input  dpf_pkg::item_t   item,
    output logic             cmd_wr,
    output dpf_pkg::cmd_t    cmd
);

    logic       in_packet_reg, in_packet_next;
    logic [7:0] sum_reg, sum_next;
    logic       accept;
    logic       esc;
    logic [7:0] esc_char;
    logic [7:0] base_sum;
    logic [7:0] add_val;
    logic [7:0] new_sum;

    assign accept = push && !full;

    // Classify the byte and work out the checksum
    always_comb
    begin
        esc      = (item.data_byte == dpf_pkg::CH_START) ||
                   (item.data_byte == dpf_pkg::CH_HASH)  ||
                   (item.data_byte == dpf_pkg::CH_ESCAPE);
        esc_char = item.data_byte ^ dpf_pkg::ESC_XOR;
        base_sum = in_packet_reg ? sum_reg : 8'h00;
        add_val  = esc ? (dpf_pkg::CH_ESCAPE + esc_char) : item.data_byte;
        new_sum  = base_sum + add_val;

        cmd.need_start = !in_packet_reg;
        cmd.has_data   = !item.empty_packet;
        cmd.escaped    = esc && !item.empty_packet;
        cmd.data_char  = esc ? esc_char : item.data_byte;
        cmd.close      = item.empty_packet || item.last_byte;
        cmd.sum        = item.empty_packet ? base_sum : new_sum;

        // a closed packet clears both the flag and the sum
        in_packet_next = in_packet_reg;
        sum_next       = sum_reg;
        if (accept)
        begin
            in_packet_next = !cmd.close;
            sum_next       = cmd.close ? 8'h00 : new_sum;
        end
    end

    assign cmd_wr = accept;

    // Packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            sum_reg       <= 8'h00;
        end
        else
        begin
            in_packet_reg <= in_packet_next;
            sum_reg       <= sum_next;
        end
    end

endmodule

FILE: rtl/core/dpf_queue.sv
// Short command queue between front and back of the framer.
// Flip-flop storage, one write (while not full) and one read (while not empty) per cycle. Uses dpf_pkg.
module dpf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  dpf_pkg::cmd_t       wr_cmd,
    input  logic                rd,
    output dpf_pkg::cmd_t       head,
    output dpf_pkg::q_status_t  status
);

    dpf_pkg::cmd_t                 entry_reg [dpf_pkg::Q_DEPTH];
    logic [dpf_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dpf_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dpf_pkg::Q_CNT_W-1:0]   count_reg, count_next;
    logic                          do_wr;
    logic                          do_rd;

    assign status.full       = (count_reg == dpf_pkg::Q_CNT_W'(dpf_pkg::Q_DEPTH));
    assign status.head_valid = (count_reg != '0);
    assign status.count      = count_reg;
    assign head              = entry_reg[rd_ptr_reg];

    assign do_wr = wr && !status.full;
    assign do_rd = rd && status.head_valid;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

FILE: rtl/core/dpf_back.sv
// Back end of the framer: walks each queued command one character per
// cycle into the output register while it is free or being drained. Uses dpf_pkg.
module dpf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  dpf_pkg::cmd_t     head,
    output logic              head_rd,
    input  logic              pop,
    output logic              out_valid,
    output dpf_pkg::result_t  result
);

    logic [5:0]         sent_reg, sent_next;
    logic               out_valid_reg, out_valid_next;
    dpf_pkg::result_t   out_reg, out_next;
    logic [5:0]         present;
    logic [5:0]         pending;
    dpf_pkg::step_t     cur;
    logic               last_char;
    logic               load_ok;
    logic               load;
    logic [7:0]         ch;

    // Characters this command still has to send
    always_comb
    begin
        present = {head.close, head.close, head.close,
                   head.has_data, head.has_data && head.escaped, head.need_start};
        pending = present & ~sent_reg;
    end

    // Oldest pending step goes first
    always_comb
    begin
        priority if (pending[0]) cur = dpf_pkg::STEP_START;
        else if (pending[1])     cur = dpf_pkg::STEP_ESC;
        else if (pending[2])     cur = dpf_pkg::STEP_DATA;
        else if (pending[3])     cur = dpf_pkg::STEP_HASH;
        else if (pending[4])     cur = dpf_pkg::STEP_HI;
        else                     cur = dpf_pkg::STEP_LO;
    end

    assign last_char = ((pending & ~cur) == 6'b000000);

    // Character for the current step
    always_comb
    begin
        unique case (cur)
            dpf_pkg::STEP_START: ch = dpf_pkg::CH_START;
            dpf_pkg::STEP_ESC:   ch = dpf_pkg::CH_ESCAPE;
            dpf_pkg::STEP_DATA:  ch = head.data_char;
            dpf_pkg::STEP_HASH:  ch = dpf_pkg::CH_HASH;
            dpf_pkg::STEP_HI:    ch = dpf_pkg::hex_digit(head.sum[7:4]);
            dpf_pkg::STEP_LO:    ch = dpf_pkg::hex_digit(head.sum[3:0]);
            default:             ch = dpf_pkg::CH_HASH;
        endcase
    end

    // Output register loads when free or being drained
    always_comb
    begin
        load_ok        = !out_valid_reg || pop;
        load           = head_valid && load_ok;
        head_rd        = load && last_char;
        sent_next      = sent_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            sent_next              = last_char ? 6'b000000 : (sent_reg | cur);
            out_next.out_byte      = ch;
            out_next.end_of_run    = last_char;
            out_next.end_of_packet = (cur == dpf_pkg::STEP_LO);
            out_valid_next         = 1'b1;
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent_reg      <= 6'b000000;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sent_reg      <= sent_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

FILE: rtl/core/debug_packet_framer.sv
// Debug packet framer top level: front, command queue, back.
// An accepted word is registered in the command queue, then its characters in the output register.
// The back sequencer gives one result word per cycle while commands wait and pop drains the output;
// an input word becomes 1 to 6 characters (plain 1, escaped 2, '$' and close add 1 and 3).
// Input words are taken every cycle while the 4-entry command queue has room.
// Reset (rst_n low, async): queue and output empty, no packet open, sum zero.
module debug_packet_framer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  dpf_pkg::item_t    item,
    input  logic              pop,
    output logic              empty,
    output dpf_pkg::result_t  result
);

    dpf_pkg::cmd_t       cmd;
    logic                cmd_wr;
    dpf_pkg::cmd_t       head;
    dpf_pkg::q_status_t  q_status;
    logic                head_rd;
    logic                out_valid;

    dpf_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (q_status.full),
        .item   (item),
        .cmd_wr (cmd_wr),
        .cmd    (cmd)
    );

    dpf_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (cmd_wr),
        .wr_cmd (cmd),
        .rd     (head_rd),
        .head   (head),
        .status (q_status)
    );

    dpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_status.head_valid),
        .head       (head),
        .head_rd    (head_rd),
        .pop        (pop),
        .out_valid  (out_valid),
        .result     (result)
    );

    assign full  = q_status.full;
    assign empty = !out_valid;

    // Checks

    // fill count never passes the queue depth
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= dpf_pkg::Q_CNT_W'(dpf_pkg::Q_DEPTH))
        else $error("command queue count out of range");

    // an accepted word leaves a command waiting or in progress
    a_q_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> (q_status.count != '0))
        else $error("accepted word lost from command queue");

    // the closing checksum digit always ends the run
    a_eop_eor: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.end_of_packet) |-> result.end_of_run)
        else $error("end of packet without end of run");

    // the closing digit is a lower-case hex character
    a_eop_hex: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.end_of_packet) |->
        ((result.out_byte >= 8'h30 && result.out_byte <= 8'h39) ||
         (result.out_byte >= 8'h61 && result.out_byte <= 8'h66)))
        else $error("checksum digit not a hex character");

endmodule
